// ===== design/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and codes of the Intel HEX record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

   localparam int unsigned TDATA_W = 56;

   localparam logic       KIND_DATA   = 1'b0;
   localparam logic       KIND_RECORD = 1'b1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_START = 3'd1;
   localparam logic [2:0] ST_TOO_LONG  = 3'd2;
   localparam logic [2:0] ST_BAD_SUM   = 3'd3;
   localparam logic [2:0] ST_BAD_DIGIT = 3'd4;

   localparam logic [7:0] MAX_LEN_RESET = 8'd16;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [15:0] load_address;
      logic [7:0]  record_type;
      logic [7:0]  data_length;
      logic [2:0]  status;
   } ihex_result_type;

endpackage

// ===== design/ihex_parse.sv =====
// ----------------------------------------------------------------------------
// ihex_parse
// Record state machine: decodes one character per beat and produces at most
// one result in the same cycle.
// ----------------------------------------------------------------------------
module ihex_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               char_code,
   input  logic                     line_start,
   input  logic [7:0]               max_len,
   output logic                     res_valid,
   output ihex_pkg::ihex_result_type res
);
   import ihex_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LEN  = 3'd1;
   localparam logic [2:0] PH_AHI  = 3'd2;
   localparam logic [2:0] PH_ALO  = 3'd3;
   localparam logic [2:0] PH_TYPE = 3'd4;
   localparam logic [2:0] PH_DATA = 3'd5;
   localparam logic [2:0] PH_CHK  = 3'd6;

   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // {invalid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = {1'b0, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b0, 4'(c - 8'h37)};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

   logic [2:0]  phase_ff, phase_in;
   logic        low_next_ff, low_next_in;
   logic [3:0]  high_ff, high_in;
   logic [7:0]  done_ff, done_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  sum_ff, sum_in;

   logic [4:0]  digit;
   logic [7:0]  byte_val;
   logic [7:0]  sum_add;
   logic        emit;
   logic        kind;
   logic [2:0]  status;

   assign digit    = hex_value(char_code);
   assign byte_val = {high_ff, digit[3:0]};
   assign sum_add  = 8'(sum_ff + byte_val);

   always_comb begin
      phase_in    = phase_ff;
      low_next_in = low_next_ff;
      high_in     = high_ff;
      done_in     = done_ff;
      len_in      = len_ff;
      addr_in     = addr_ff;
      type_in     = type_ff;
      sum_in      = sum_ff;
      emit        = 1'b0;
      kind        = KIND_RECORD;
      status      = ST_OK;

      if (line_start) begin
         low_next_in = 1'b0;
         high_in     = '0;
         done_in     = '0;
         len_in      = '0;
         addr_in     = '0;
         type_in     = '0;
         sum_in      = '0;
         if (char_code == CHAR_COLON) begin
            phase_in = PH_LEN;
         end else begin
            phase_in = PH_IDLE;
            emit     = 1'b1;
            status   = ST_BAD_START;
         end
      end else if (phase_ff == PH_IDLE || phase_ff > PH_CHK) begin
         phase_in = PH_IDLE;
      end else if (digit[4]) begin
         phase_in = PH_IDLE;
         emit     = 1'b1;
         status   = ST_BAD_DIGIT;
      end else if (!low_next_ff) begin
         high_in     = digit[3:0];
         low_next_in = 1'b1;
      end else begin
         low_next_in = 1'b0;
         case (phase_ff)
            PH_LEN: begin
               len_in = byte_val;
               sum_in = sum_add;
               if (byte_val > max_len) begin
                  phase_in = PH_IDLE;
                  emit     = 1'b1;
                  status   = ST_TOO_LONG;
               end else begin
                  phase_in = PH_AHI;
               end
            end
            PH_AHI: begin
               addr_in  = {byte_val, 8'h00};
               sum_in   = sum_add;
               phase_in = PH_ALO;
            end
            PH_ALO: begin
               addr_in  = {addr_ff[15:8], byte_val};
               sum_in   = sum_add;
               phase_in = PH_TYPE;
            end
            PH_TYPE: begin
               type_in  = byte_val;
               sum_in   = sum_add;
               phase_in = (len_ff != 8'd0) ? PH_DATA : PH_CHK;
            end
            PH_DATA: begin
               sum_in  = sum_add;
               emit    = 1'b1;
               kind    = KIND_DATA;
               done_in = 8'(done_ff + 8'd1);
               if (done_in == len_ff) begin
                  phase_in = PH_CHK;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               emit     = 1'b1;
               status   = (sum_add == 8'd0) ? ST_OK : ST_BAD_SUM;
            end
         endcase
      end
   end

   // record fields come from the updated state: a too-long record reports its length
   always_comb begin
      res.kind         = kind;
      res.data_byte    = (kind == KIND_DATA) ? byte_val : 8'd0;
      res.byte_index   = (kind == KIND_DATA) ? done_ff : 8'd0;
      res.load_address = addr_in;
      res.record_type  = type_in;
      res.data_length  = len_in;
      res.status       = status;
   end

   assign res_valid = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         low_next_ff <= 1'b0;
         high_ff     <= '0;
         done_ff     <= '0;
         len_ff      <= '0;
         addr_ff     <= '0;
         type_ff     <= '0;
         sum_ff      <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         low_next_ff <= low_next_in;
         high_ff     <= high_in;
         done_ff     <= done_in;
         len_ff      <= len_in;
         addr_ff     <= addr_in;
         type_ff     <= type_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

// ===== design/intel_hex_record_parser.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// Parses Intel HEX text one character per beat into data bytes and records.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one ASCII character per beat; req_tuser flags the first
//            character of a line (a ':' there opens a record).
//   rsp_*  : a data byte result (rsp_tuser = 0) for every data byte, and one
//            record result (rsp_tuser = 1) with status when a record ends,
//            fails or a line starts with something other than ':'.
//   csr_*  : writes max_data_length; always ready, use only while idle.
// Output: a result is registered in the output register behind rsp_*, or in
//   the skid entry while rsp_* stalls. Throughput: one character per cycle
//   while req_tready is high; the record state update (digit decode, 8-bit
//   add, phase step) is combinational. Stall: an output register plus one
//   skid entry; req_tready drops only when both hold results.
// Reset: synchronous; parser goes idle, buffers empty, max_data_length = 16.
// ----------------------------------------------------------------------------
module intel_hex_record_parser (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [7:0]                    csr_data,      // max_data_length
   // character input
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,     // [7:0] char_code
   input  logic                          req_tuser,     // line_start
   // results
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] data_byte, [15:8] byte_index, [31:16] load_address,
   // [39:32] record_type, [47:40] data_length, [50:48] status, rest zero
   output logic [ihex_pkg::TDATA_W-1:0]  rsp_tdata,
   output logic                          rsp_tuser      // kind
);
   import ihex_pkg::*;

   logic [7:0]      max_len_ff;
   logic            res_valid;
   ihex_result_type res;

   logic            out_valid_ff, out_valid_in;
   ihex_result_type out_ff, out_in;
   logic            skid_valid_ff, skid_valid_in;
   ihex_result_type skid_ff, skid_in;

   logic            accept;
   logic            take;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_data;
      end
   end

   ihex_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_code  (req_tdata),
      .line_start (req_tuser),
      .max_len    (max_len_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = res;
         end
      end else if (res_valid) begin
         // output stalled: park the new result
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {5'd0, out_ff.status, out_ff.data_length, out_ff.record_type,
                        out_ff.load_address, out_ff.byte_index, out_ff.data_byte};

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_stall_parks: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && res_valid) |=> skid_valid_ff)
      else $error("result lost while output stalled");

   a_data_status_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_DATA) |-> (out_ff.status == ST_OK))
      else $error("data byte result with nonzero status");
`endif

endmodule

// ===== dv/ihex_record_checker.sv =====
// ----------------------------------------------------------------------------
// ihex_record_checker
// Watches the character, result and register channels of the Intel HEX
// parser, predicts every result from the accepted characters and compares
// each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module ihex_record_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [7:0]                    csr_data,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [7:0]                    req_tdata,
   input  logic                          req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [ihex_pkg::TDATA_W-1:0]  rsp_tdata,
   input  logic                          rsp_tuser,
   output int                            error_count,
   output int                            pending_count
);
   import ihex_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] COLON_CHAR = 8'h3A;
   localparam int         REPORT_MAX = 10;

   typedef enum logic [2:0] {
      PARSE_IDLE, PARSE_LENGTH, PARSE_ADDR_HI, PARSE_ADDR_LO,
      PARSE_TYPE, PARSE_DATA, PARSE_CHECKSUM
   } parse_phase_type;

   parse_phase_type parse_phase;
   logic            low_nibble_pending;
   logic [3:0]      high_digit;
   logic [7:0]      data_count;
   logic [7:0]      record_length;
   logic [15:0]     record_address;
   logic [7:0]      record_kind;
   logic [7:0]      byte_sum;
   logic [7:0]      length_limit;

   ihex_result_type expected_results[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // 0..15 for a hex digit of either case, 16 otherwise
   function automatic logic [4:0] nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
      return 5'd16;
   endfunction

   function automatic ihex_result_type record_result(logic kind, logic [7:0] value,
                                                     logic [7:0] index, logic [2:0] status);
      ihex_result_type r;
      r.kind         = kind;
      r.data_byte    = value;
      r.byte_index   = index;
      r.load_address = record_address;
      r.record_type  = record_kind;
      r.data_length  = record_length;
      r.status       = status;
      return r;
   endfunction

   task automatic clear_record();
      low_nibble_pending = 1'b0;
      high_digit         = '0;
      data_count         = '0;
      record_length      = '0;
      record_address     = '0;
      record_kind        = '0;
      byte_sum           = '0;
   endtask

   task automatic close_record(logic [2:0] status);
      expected_results.push_back(record_result(KIND_RECORD, 8'd0, 8'd0, status));
      parse_phase = PARSE_IDLE;
   endtask

   task automatic predict_char(logic [7:0] c, logic first);
      logic [4:0] digit;
      logic [7:0] value;
      if (first) begin
         clear_record();
         if (c == COLON_CHAR)
            parse_phase = PARSE_LENGTH;
         else
            close_record(ST_BAD_START);
         return;
      end
      if (parse_phase == PARSE_IDLE)
         return;
      digit = nibble_of(c);
      if (digit[4]) begin
         close_record(ST_BAD_DIGIT);
         return;
      end
      if (!low_nibble_pending) begin
         high_digit         = digit[3:0];
         low_nibble_pending = 1'b1;
         return;
      end
      low_nibble_pending = 1'b0;
      value = {high_digit, digit[3:0]};
      case (parse_phase)
         PARSE_LENGTH: begin
            record_length = value;
            byte_sum += value;
            if (value > length_limit)
               close_record(ST_TOO_LONG);
            else
               parse_phase = PARSE_ADDR_HI;
         end
         PARSE_ADDR_HI: begin
            record_address = {value, 8'h00};
            byte_sum += value;
            parse_phase = PARSE_ADDR_LO;
         end
         PARSE_ADDR_LO: begin
            record_address[7:0] = value;
            byte_sum += value;
            parse_phase = PARSE_TYPE;
         end
         PARSE_TYPE: begin
            record_kind = value;
            byte_sum += value;
            parse_phase = (record_length != 0) ? PARSE_DATA : PARSE_CHECKSUM;
         end
         PARSE_DATA: begin
            byte_sum += value;
            expected_results.push_back(record_result(KIND_DATA, value, data_count, ST_OK));
            data_count++;
            if (data_count == record_length)
               parse_phase = PARSE_CHECKSUM;
         end
         default: begin
            close_record((8'(byte_sum + value) == 8'd0) ? ST_OK : ST_BAD_SUM);
         end
      endcase
   endtask

   task automatic check_result();
      ihex_result_type seen, want;
      logic [TDATA_W-52:0] pad;
      seen.kind         = rsp_tuser;
      seen.data_byte    = rsp_tdata[7:0];
      seen.byte_index   = rsp_tdata[15:8];
      seen.load_address = rsp_tdata[31:16];
      seen.record_type  = rsp_tdata[39:32];
      seen.data_length  = rsp_tdata[47:40];
      seen.status       = rsp_tdata[50:48];
      pad               = rsp_tdata[TDATA_W-1:51];
      if (expected_results.size() == 0) begin
         if (error_count < REPORT_MAX)
            $display("%0t: result beat with nothing expected: kind=%0d byte=%02h idx=%0d",
                     $realtime, seen.kind, seen.data_byte, seen.byte_index);
         error_count++;
         return;
      end
      want = expected_results.pop_front();
      if (seen !== want || pad !== '0) begin
         if (error_count < REPORT_MAX) begin
            $display("%0t: result mismatch", $realtime);
            $display("   expected kind=%0d byte=%02h idx=%0d addr=%04h",
                     want.kind, want.data_byte, want.byte_index, want.load_address);
            $display("            type=%02h len=%0d st=%0d",
                     want.record_type, want.data_length, want.status);
            $display("   actual   kind=%0d byte=%02h idx=%0d addr=%04h",
                     seen.kind, seen.data_byte, seen.byte_index, seen.load_address);
            $display("            type=%02h len=%0d st=%0d pad=%h",
                     seen.record_type, seen.data_length, seen.status, pad);
         end
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         parse_phase  = PARSE_IDLE;
         length_limit = MAX_LEN_RESET;
         clear_record();
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready)
            length_limit = csr_data;
         // the result on rsp always belongs to an earlier character
         if (req_tvalid && req_tready)
            predict_char(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready)
            check_result();
      end
      pending_count <= expected_results.size();
   end

endmodule

// ===== dv/intel_hex_record_parser_test.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_parser_test
// Feeds the parser directed and random Intel HEX text (good records, bad
// checksums, bad digits, overlong and cut-off records, junk) under several
// length limits with random stalls on both streams; the checker module
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_test;
   import ihex_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] COLON_CHAR     = 8'h3A;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         PHASE_CHARS    = 240;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_data   = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;
   logic               req_tuser  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b1;
   logic [TDATA_W-1:0] rsp_tdata;
   logic               rsp_tuser;

   int                 error_count;
   int                 pending_count;
   int                 idle_cycles = 0;
   int                 stall_left  = 0;
   int                 gap_odds    = 0;
   int                 stall_odds  = 0;
   int                 chars_sent  = 0;
   int                 char_target = 0;
   logic [7:0]         current_limit = MAX_LEN_RESET;

   always #2 clock = ~clock;

   intel_hex_record_parser dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ihex_record_checker result_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // result side back-pressure: rsp_tready drops in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left <= $urandom_range(1, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic drive_char(logic [7:0] c, logic first);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_char(logic [7:0] c, logic first);
      drive_char(c, first);
      chars_sent++;
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 10) return 8'("0" + n);
      return ($urandom_range(0, 1) != 0) ? 8'("A" + n - 10) : 8'("a" + n - 10);
   endfunction

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == 0);
   endtask

   // stop the character stream and wait for every predicted result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_limit(logic [7:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      current_limit  = value;
   endtask

   task automatic send_random_record();
      int unsigned pick, len, cut_at, top;
      logic [15:0] addr;
      logic [7:0]  sum;
      logic [7:0]  bad;
      logic [7:0]  rec_bytes[$];
      pick = $urandom_range(0, 15);
      if (pick == 15) begin
         // junk at the head of a line
         do bad = 8'($urandom_range(0, 255)); while (bad == COLON_CHAR);
         send_char(bad, 1'b1);
         return;
      end
      if (pick == 14 && current_limit < 255) begin
         len = $urandom_range(current_limit + 1, 255);
         send_char(COLON_CHAR, 1'b1);
         send_char(hex_char(len[7:4]), 1'b0);
         send_char(hex_char(len[3:0]), 1'b0);
         return;
      end
      top = (current_limit < 8) ? current_limit : 8;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, current_limit)
                                         : $urandom_range(0, top);
      addr = 16'($urandom);
      rec_bytes.push_back(8'(len));
      rec_bytes.push_back(addr[15:8]);
      rec_bytes.push_back(addr[7:0]);
      rec_bytes.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < len; i++)
         rec_bytes.push_back(8'($urandom_range(0, 255)));
      sum = '0;
      foreach (rec_bytes[i]) sum += rec_bytes[i];
      sum = -sum;
      if (pick == 10 || pick == 11)
         sum ^= 8'($urandom_range(1, 255));
      rec_bytes.push_back(sum);
      cut_at = (pick == 12 || pick == 13) ? $urandom_range(0, 2 * rec_bytes.size() - 1)
                                          : 2 * rec_bytes.size();
      send_char(COLON_CHAR, 1'b1);
      for (int k = 0; k < 2 * rec_bytes.size(); k++) begin
         if (k == cut_at) begin
            if (pick == 12) begin
               do bad = 8'($urandom_range(0, 255));
               while ((bad >= "0" && bad <= "9") || (bad >= "a" && bad <= "f") ||
                      (bad >= "A" && bad <= "F"));
               send_char(bad, 1'b0);
            end
            return;
         end
         send_char(hex_char((k % 2 == 0) ? rec_bytes[k / 2][7:4] : rec_bytes[k / 2][3:0]),
                   1'b0);
      end
      // stray text between records, parser is idle so it is dropped
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) drive_char(8'($urandom_range(0, 255)), 1'b0);
   endtask

   initial begin
      int limits[6];
      int gaps[6];
      int stalls[6];
      limits = '{16, 0, 255, 0, 1, 8};
      gaps   = '{6, 3, 0, 10, 5, 0};
      stalls = '{5, 3, 0, 8, 6, 0};
      limits[3] = $urandom_range(2, 254);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty record with a bad checksum, a lowercase data record,
      // bad digit, overlong length, junk line start, ignored stray text
      send_text(":00000001FE");
      send_text(":011234a056c3");
      send_text(":G");
      send_text(":FF");
      send_char(8'h00, 1'b1);
      drive_char(8'hFF, 1'b0);
      drive_char(COLON_CHAR, 1'b0);

      for (int p = 0; p < 6; p++) begin
         gap_odds   = gaps[p];
         stall_odds = stalls[p];
         if (p > 0)
            program_limit(8'(limits[p]));
         char_target += PHASE_CHARS;
         while (chars_sent < char_target) begin
            send_random_record();
            // in phase 1, pause for all outstanding results after each record ending mid-phase
            if (p == 1 && chars_sent >= char_target - PHASE_CHARS / 2 &&
                chars_sent < char_target - PHASE_CHARS / 2 + 30)
               drain();
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
design/ihex_pkg.sv
design/ihex_parse.sv
design/intel_hex_record_parser.sv
dv/ihex_record_checker.sv
dv/intel_hex_record_parser_test.sv
